>>> hw/rtl/pct_esc_pkg.sv
// Shared types and constants for the percent escape encoder.
`default_nettype none

package pct_esc_pkg;

  // Escape form chosen by the classifier.
  typedef enum logic [1:0] {
    KIND_SAFE  = 2'd0,  // character passes through as is
    KIND_SHORT = 2'd1,  // %XX
    KIND_LONG  = 2'd2   // %uXXXX
  } kind_t;

  localparam int CODE_W = 16;
  localparam int CHAR_W = 7;
  localparam int STEP_W = 3;

  // Step index of the final character of each form.
  localparam logic [STEP_W-1:0] LAST_STEP_SAFE  = 3'd0;
  localparam logic [STEP_W-1:0] LAST_STEP_SHORT = 3'd2;
  localparam logic [STEP_W-1:0] LAST_STEP_LONG  = 3'd5;

  // Classified item queued between front and back.
  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/pct_esc_front.sv
// Front end: takes character codes and classifies their escape form.
`default_nettype none

module pct_esc_front (
  input  wire logic [pct_esc_pkg::CODE_W-1:0] char_code,
  output pct_esc_pkg::item_t                  item
);

  logic is_upper;
  logic is_lower;
  logic is_digit;
  logic is_punct;
  logic is_safe;

  always_comb begin
    is_upper = (char_code >= 16'h0041) && (char_code <= 16'h005A);
    is_lower = (char_code >= 16'h0061) && (char_code <= 16'h007A);
    is_digit = (char_code >= 16'h0030) && (char_code <= 16'h0039);
    // @ * _ + - . /
    is_punct = (char_code == 16'h0040) || (char_code == 16'h002A) ||
               (char_code == 16'h005F) || (char_code == 16'h002B) ||
               (char_code == 16'h002D) || (char_code == 16'h002E) ||
               (char_code == 16'h002F);
    is_safe  = is_upper || is_lower || is_digit || is_punct;

    item.code = char_code;
    if (is_safe) begin
      item.kind = pct_esc_pkg::KIND_SAFE;
    end else if (char_code[15:8] == 8'h00) begin
      item.kind = pct_esc_pkg::KIND_SHORT;
    end else begin
      item.kind = pct_esc_pkg::KIND_LONG;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pct_esc_queue.sv
// Small FIFO of classified items between front and back.
`default_nettype none

module pct_esc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  pct_esc_pkg::item_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output pct_esc_pkg::item_t      head_item,
  output logic                    head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  pct_esc_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_MAX);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pct_esc_back.sv
// Back end: walks each queued item and emits its characters, one per cycle while the output is not stalled.
`default_nettype none

module pct_esc_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           hex_lowercase,
  input  pct_esc_pkg::item_t                  head_item,
  input  wire logic                           head_valid,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pct_esc_pkg::CHAR_W-1:0]      out_char,
  output logic                                run_last
);

  logic [pct_esc_pkg::STEP_W-1:0] step;
  logic [pct_esc_pkg::STEP_W-1:0] last_step;
  logic [pct_esc_pkg::CHAR_W-1:0] char_next;
  logic [3:0]                     nib;
  logic                           is_last;
  logic                           load;

  function automatic logic [pct_esc_pkg::CHAR_W-1:0] hex_char(
    input logic [3:0] n,
    input logic       lower
  );
    logic [pct_esc_pkg::CHAR_W-1:0] base;
    begin
      base = lower ? 7'h61 : 7'h41;  // 'a' or 'A'
      if (n < 4'd10) begin
        hex_char = 7'h30 + {3'b000, n};
      end else begin
        hex_char = base + {3'b000, n - 4'd10};
      end
    end
  endfunction

  always_comb begin
    case (head_item.kind)
      pct_esc_pkg::KIND_SAFE:  last_step = pct_esc_pkg::LAST_STEP_SAFE;
      pct_esc_pkg::KIND_SHORT: last_step = pct_esc_pkg::LAST_STEP_SHORT;
      pct_esc_pkg::KIND_LONG:  last_step = pct_esc_pkg::LAST_STEP_LONG;
      default:                 last_step = pct_esc_pkg::LAST_STEP_SAFE;
    endcase
    is_last = (step == last_step);

    // Digit to print: the final digits are always the low byte.
    case (step)
      3'd1:    nib = head_item.code[7:4];
      3'd2:    nib = (head_item.kind == pct_esc_pkg::KIND_LONG) ?
                     head_item.code[15:12] : head_item.code[3:0];
      3'd3:    nib = head_item.code[11:8];
      3'd4:    nib = head_item.code[7:4];
      3'd5:    nib = head_item.code[3:0];
      default: nib = head_item.code[3:0];
    endcase

    if (head_item.kind == pct_esc_pkg::KIND_SAFE) begin
      char_next = head_item.code[6:0];
    end else if (step == 3'd0) begin
      char_next = 7'h25;  // '%'
    end else if (step == 3'd1 && head_item.kind == pct_esc_pkg::KIND_LONG) begin
      char_next = 7'h75;  // 'u'
    end else begin
      char_next = hex_char(nib, hex_lowercase);
    end

    load = head_valid && (!out_valid || out_ready);
    pop  = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= is_last ? '0 : step + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      run_last <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/percent_escape_encoder.sv
// Percent escape encoder: 16-bit character codes in, escaped ASCII out.
// An input transaction passes through the item queue register and then the
//   output register before its first output character appears.
// Throughput: one output character per cycle while m_axis_tready does not stall,
//   with 1, 3 or 6 characters per input for the safe, %XX and %uXXXX forms; the single character emit unit sets it.
// Reset (rst, synchronous, active high) empties the queue, drops any pending
//   output and sets hex_lowercase to 0 (uppercase hex digits).
`default_nettype none

module percent_escape_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: hex_lowercase register
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_code
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [6:0] out_char, [7] zero pad
  output logic             m_axis_tlast    // run_last
);

  logic                                 hex_lowercase;
  pct_esc_pkg::item_t                   front_item;
  pct_esc_pkg::item_t                   head_item;
  logic                                 queue_full;
  logic                                 head_valid;
  logic                                 pop;
  logic [pct_esc_pkg::CHAR_W-1:0]       out_char;

  // Config register; the user must write it only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      hex_lowercase <= 1'b0;
    end else if (cfg_we) begin
      hex_lowercase <= cfg_wdata;
    end
  end

  // Front accepts whenever the queue has room; the back drains it
  // independently, so a stalled output does not block input until full.
  assign s_axis_tready = !queue_full;

  pct_esc_front u_front (
    .char_code (s_axis_tdata),
    .item      (front_item)
  );

  pct_esc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_item  (head_item),
    .head_valid (head_valid)
  );

  // Back emits characters into a registered output stage.
  pct_esc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .hex_lowercase (hex_lowercase),
    .head_item     (head_item),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_char      (out_char),
    .run_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

>>> verif/percent_escape_encoder_tb.sv
// Self-checking testbench for the percent escape encoder stream block.
`timescale 1ns / 100ps

module percent_escape_encoder_tb;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned PRINT_CAP   = 40;
  localparam int unsigned TAIL_CYCLES = 8;

  // Tracks the escaped characters the encoder still owes, in order.
  class escape_scoreboard;
    bit          hex_lower;
    bit [6:0]    char_q[$];
    bit          last_q[$];
    int unsigned mismatches;

    function void set_lowercase(bit lower);
      hex_lower = lower;
    endfunction

    function int unsigned pending();
      return char_q.size();
    endfunction

    function bit [7:0] hex_char(bit [3:0] nib);
      bit [7:0] ch;
      if (nib < 4'd10)
        ch = 8'("0") + 8'(nib);
      else
        ch = (hex_lower ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
      return ch;
    endfunction

    function void push_char(bit [7:0] ch, bit last);
      char_q.push_back(ch[6:0]);
      last_q.push_back(last);
    endfunction

    // Accepted input transaction: queue its 1, 3 or 6 output characters.
    function void note_code(bit [15:0] code);
      pct_esc_pkg::kind_t kind;
      if ((code >= "A" && code <= "Z") || (code >= "a" && code <= "z") ||
          (code >= "0" && code <= "9") || code == "@" || code == "*" ||
          code == "_" || code == "+" || code == "-" || code == "." || code == "/")
        kind = pct_esc_pkg::KIND_SAFE;
      else if (code <= 16'h00FF)
        kind = pct_esc_pkg::KIND_SHORT;
      else
        kind = pct_esc_pkg::KIND_LONG;

      case (kind)
        pct_esc_pkg::KIND_SAFE: begin
          push_char(code[7:0], 1'b1);
        end
        pct_esc_pkg::KIND_SHORT: begin
          push_char("%", 1'b0);
          push_char(hex_char(code[7:4]), 1'b0);
          push_char(hex_char(code[3:0]), 1'b1);
        end
        default: begin
          push_char("%", 1'b0);
          push_char("u", 1'b0);
          push_char(hex_char(code[15:12]), 1'b0);
          push_char(hex_char(code[11:8]), 1'b0);
          push_char(hex_char(code[7:4]), 1'b0);
          push_char(hex_char(code[3:0]), 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Output transaction: compare with the oldest owed character.
    task check_char(bit [6:0] ch, bit last, bit pad);
      bit [6:0] want_ch;
      bit       want_last;
      if (char_q.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last %0d", ch, last));
        return;
      end
      want_ch   = char_q.pop_front();
      want_last = last_q.pop_front();
      if (ch != want_ch)
        report($sformatf("out_char 0x%02h, want 0x%02h", ch, want_ch));
      if (last != want_last)
        report($sformatf("run_last %0d, want %0d (char 0x%02h)", last, want_last, want_ch));
      if (pad != 1'b0)
        report("tdata pad bit set");
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [6:0] out_char, [7] zero pad
  logic        m_axis_tlast;        // run_last

  escape_scoreboard board = new();
  int unsigned      cycles = 0;
  bit               send_idle = 1'b0;
  bit               sink_idle = 1'b0;
  int unsigned      stall_left = 0;

  // Class boundaries, every safe group, short and long forms.
  logic [15:0] corner_codes [24] = '{
    16'h0000, 16'hFFFF, 16'h0041, 16'h005A, 16'h0061, 16'h007A, 16'h0030, 16'h0039,
    16'h0040, 16'h002A, 16'h005F, 16'h002B, 16'h002D, 16'h002E, 16'h002F, 16'h0020,
    16'h003A, 16'h0060, 16'h007F, 16'h00FF, 16'h0100, 16'h1234, 16'hABCD, 16'h8000
  };

  percent_escape_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias toward pass-through characters, then byte codes, then any code.
  function automatic logic [15:0] random_code();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      case ($urandom_range(0, 3))
        0: return 16'("A") + 16'($urandom_range(0, 25));
        1: return 16'("a") + 16'($urandom_range(0, 25));
        2: return 16'("0") + 16'($urandom_range(0, 9));
        default: begin
          case ($urandom_range(0, 6))
            0: return 16'("@");
            1: return 16'("*");
            2: return 16'("_");
            3: return 16'("+");
            4: return 16'("-");
            5: return 16'(".");
            default: return 16'("/");
          endcase
        end
      endcase
    end
    if (pick < 7)
      return 16'($urandom_range(0, 255));
    return 16'($urandom());
  endfunction

  // Output side: random backpressure, one update per falling edge.
  always @(negedge clk) begin
    if (stall_left == 0 && sink_idle)
      stall_left = pick_gap(1'b1);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output monitor, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_char(m_axis_tdata[6:0], m_axis_tlast, m_axis_tdata[7]);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[percent_escape_encoder] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back transactions need no re-raise.
  task automatic send_code(input logic [15:0] code);
    int unsigned gap;
    gap = pick_gap(send_idle);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_code(code);
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed character has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write only while idle; takes effect at the next rising edge.
  task automatic set_hex_case(input bit lower);
    cfg_we    <= 1'b1;
    cfg_wdata <= lower;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_lowercase(lower);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_code(random_code());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Uppercase, corners, no idling on either side.
    set_hex_case(1'b0);
    foreach (corner_codes[i]) send_code(corner_codes[i]);
    drain();

    // Lowercase, corners again and random codes with gaps and backpressure.
    set_hex_case(1'b1);
    send_idle = 1'b1;
    sink_idle = 1'b1;
    foreach (corner_codes[i]) send_code(corner_codes[i]);
    send_random(30);
    drain();

    // Uppercase, random with idling, then a stretch at full rate.
    set_hex_case(1'b0);
    send_random(40);
    send_idle = 1'b0;
    sink_idle = 1'b0;
    send_random(25);
    drain();

    // Lowercase, sender bursty against a steady sink, then the reverse.
    set_hex_case(1'b1);
    send_idle = 1'b1;
    send_random(20);
    send_idle = 1'b0;
    sink_idle = 1'b1;
    send_random(20);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("[percent_escape_encoder] OK");
    else
      $display("[percent_escape_encoder] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pct_esc_pkg.sv
hw/rtl/pct_esc_front.sv
hw/rtl/pct_esc_queue.sv
hw/rtl/pct_esc_back.sv
hw/rtl/percent_escape_encoder.sv
verif/percent_escape_encoder_tb.sv
